### rtl/rkd_pkg.sv
// Package for the rotary knob step decoder: widths, codes, payload and state types.
package rkd_pkg;

	// Width of the internal wrapping position counter
	localparam int unsigned POS_BITS = 16;
	// Width of the internal saturating elapsed-tick counter
	localparam int unsigned TICK_BITS = 16;

	// Event mask bits
	localparam logic [7:0] EV_START     = 8'h01;
	localparam logic [7:0] EV_STOP      = 8'h02;
	localparam logic [7:0] EV_CW        = 8'h04;
	localparam logic [7:0] EV_CW_START  = 8'h08;
	localparam logic [7:0] EV_CW_STOP   = 8'h10;
	localparam logic [7:0] EV_CCW       = 8'h20;
	localparam logic [7:0] EV_CCW_START = 8'h40;
	localparam logic [7:0] EV_CCW_STOP  = 8'h80;

	// Step direction codes
	typedef enum logic [1:0] {
		DIR_IDLE = 2'd0,
		DIR_CW   = 2'd1,
		DIR_CCW  = 2'd2
	} dir_t;

	// One pin sample
	typedef struct packed {
		logic a_level;
		logic b_level;
	} in_t;

	// One decoded result
	typedef struct packed {
		logic [7:0]         event_mask;
		logic [1:0]         step_dir;
		logic signed [15:0] position;
		logic [15:0]        elapsed_ticks;
	} out_t;

	// Decoder state carried from one sample to the next
	typedef struct packed {
		logic                 prev_a;
		logic                 latched_b;
		logic                 armed;
		logic [TICK_BITS-1:0] tick_count;
		logic [POS_BITS-1:0]  step_position;
		dir_t                 prev_dir;
	} state_t;

endpackage

### rtl/rotary_knob_step_decoder_core.sv
// Rotary knob step decoder top level: input register, decode logic, result register.
// Takes one A/B pin sample per clock and returns one result per sample. A sample
// transferred on the input channel is held in the input register, decoded against
// the stored knob state and then captured in the result register, from which its
// result is offered. Throughput is one sample per cycle; both stages hold while the
// result is not taken. The active pin level is written through the cfg channel,
// which is always ready, and applies to both phases.
module rotary_knob_step_decoder_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rkd_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rkd_pkg::out_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_data
);

	logic            act_level_q;
	logic            valid_s1;
	rkd_pkg::in_t    sample_s1;
	rkd_pkg::state_t state_q;
	rkd_pkg::state_t state_nxt;
	rkd_pkg::out_t   result;
	logic            out_valid_q;
	rkd_pkg::out_t   out_data_q;
	logic            stall;
	logic            advance;

	// Pipeline control
	assign stall     = out_valid_q && !out_ready;
	assign advance   = valid_s1 && !stall;
	assign in_ready  = !valid_s1 || !stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_level_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			act_level_q <= cfg_data;
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= in_data;
		end
	end

	rkd_step_logic u_step_logic (
		.sample    (sample_s1),
		.act_level (act_level_q),
		.cur       (state_q),
		.nxt       (state_nxt),
		.result    (result)
	);

	// Knob state, updated as each sample moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{prev_a: 1'b0, latched_b: 1'b0, armed: 1'b0,
				tick_count: '0, step_position: '0, prev_dir: rkd_pkg::DIR_IDLE};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

endmodule

### rtl/rkd_event_enc.sv
// Event mask encoder: compares this sample's direction with the previous one.
module rkd_event_enc (
	input  rkd_pkg::dir_t from_dir,
	input  rkd_pkg::dir_t to_dir,
	output logic [7:0]    event_mask
);

	always_comb begin
		event_mask = '0;
		if (from_dir == to_dir) begin
			// Steady: only the direction bit, nothing while idle
			case (to_dir)
				rkd_pkg::DIR_CW:  event_mask = rkd_pkg::EV_CW;
				rkd_pkg::DIR_CCW: event_mask = rkd_pkg::EV_CCW;
				default:          event_mask = '0;
			endcase
		end else begin
			case (from_dir)
				rkd_pkg::DIR_CW: begin
					if (to_dir == rkd_pkg::DIR_IDLE)
						event_mask = rkd_pkg::EV_STOP | rkd_pkg::EV_CW_STOP;
					else
						event_mask = rkd_pkg::EV_CW_STOP | rkd_pkg::EV_CCW_START
							| rkd_pkg::EV_CCW;
				end
				rkd_pkg::DIR_CCW: begin
					if (to_dir == rkd_pkg::DIR_IDLE)
						event_mask = rkd_pkg::EV_STOP | rkd_pkg::EV_CCW_STOP;
					else
						event_mask = rkd_pkg::EV_CCW_STOP | rkd_pkg::EV_CW_START
							| rkd_pkg::EV_CW;
				end
				default: begin
					// Leaving idle: start plus the new direction
					if (to_dir == rkd_pkg::DIR_CW)
						event_mask = rkd_pkg::EV_START | rkd_pkg::EV_CW_START
							| rkd_pkg::EV_CW;
					else
						event_mask = rkd_pkg::EV_START | rkd_pkg::EV_CCW_START
							| rkd_pkg::EV_CCW;
				end
			endcase
		end
	end

endmodule

### rtl/rkd_step_logic.sv
// Per-sample decode logic: next decoder state and the result for one pin sample.
module rkd_step_logic (
	input  rkd_pkg::in_t    sample,
	input  logic            act_level,
	input  rkd_pkg::state_t cur,
	output rkd_pkg::state_t nxt,
	output rkd_pkg::out_t   result
);

	logic          a_edge;
	logic          a_act;
	rkd_pkg::dir_t dir;
	logic [7:0]    event_mask;

	assign a_edge = sample.a_level != cur.prev_a;
	assign a_act  = sample.a_level == act_level;

	// Arm / disarm and step detection
	always_comb begin
		nxt        = cur;
		dir        = rkd_pkg::DIR_IDLE;
		nxt.prev_a = sample.a_level;
		if (!cur.armed) begin
			if (a_edge && a_act) begin
				nxt.latched_b  = sample.b_level;
				nxt.tick_count = '0;
				nxt.armed      = 1'b1;
			end
		end else if (a_edge) begin
			if (!a_act) begin
				nxt.armed = 1'b0;
				if (cur.latched_b != sample.b_level) begin
					if (sample.b_level == act_level) begin
						dir               = rkd_pkg::DIR_CW;
						nxt.step_position = cur.step_position + 1'b1;
					end else begin
						dir               = rkd_pkg::DIR_CCW;
						nxt.step_position = cur.step_position - 1'b1;
					end
				end
			end else begin
				nxt.latched_b  = sample.b_level;
				nxt.tick_count = '0;
			end
		end else if (cur.tick_count != '1) begin
			// Armed with A steady: count, saturating
			nxt.tick_count = cur.tick_count + 1'b1;
		end
		nxt.prev_dir = dir;
	end

	rkd_event_enc u_event_enc (
		.from_dir   (cur.prev_dir),
		.to_dir     (dir),
		.event_mask (event_mask)
	);

	// Result fields
	always_comb begin
		result.event_mask    = event_mask;
		result.step_dir      = dir;
		result.position      = 16'(nxt.step_position);
		result.elapsed_ticks = 16'(nxt.tick_count);
	end

endmodule
